// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expr must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/fnw_pkg.sv =====
// ---------------------------------------------------------------------------
// fnw_pkg
// Shared constants for the first-negative-in-window block.
// ---------------------------------------------------------------------------
package fnw_pkg;

   // window length CSR write width and its reset value
   localparam int CSR_WIDTH   = 9;
   localparam int WLEN_RESET  = 1;

endpackage

// ===== rtl/first_negative_in_window.sv =====
// Throughput: one request per cycle while req_ready is high; it drops while the skid stage is full.
// Results: a request that fills its window is registered on rsp_*, or in the skid stage.
// The two oldest queue entries live in registers; the memory port prefetches
// the third every cycle, so a pop and a push can both happen on one request.
// Reset (synchronous): queue, position and fill counters cleared, window
// length set to 1; the entry memory is not cleared.
// ---------------------------------------------------------------------------
// first_negative_in_window
// Oldest negative sample in each sliding window, from a memory-backed queue
// of negative samples tagged with their stream position.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module first_negative_in_window #(
   parameter int WINDOW_MAX   = 256,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_wr_en,
   input  logic [fnw_pkg::CSR_WIDTH-1:0]  csr_wr_data,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_last_sample,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_first_negative,
   output logic                           rsp_end_of_stream
);
   import fnw_pkg::*;

   localparam int IW = $clog2(WINDOW_MAX);        // memory index
   localparam int CW = $clog2(WINDOW_MAX + 1);    // count / window length
   localparam int PW = $clog2(2 * WINDOW_MAX);    // position, modulo 2*W

   // memory
   logic [SAMPLE_WIDTH-1:0] val_mem [WINDOW_MAX];
   logic [PW-1:0]           pos_mem [WINDOW_MAX];
   logic [SAMPLE_WIDTH-1:0] rd_val_ff;
   logic [PW-1:0]           rd_pos_ff;
   logic                    fwd_ff;
   logic [SAMPLE_WIDTH-1:0] fwd_val_ff;
   logic [PW-1:0]           fwd_pos_ff;

   // control state
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [CW-1:0] seen_ff, seen_in;
   logic [CW-1:0] wlen_ff;

   // front entries of the queue
   logic [SAMPLE_WIDTH-1:0] h0_val_ff, h0_val_in, h1_val_ff, h1_val_in;
   logic [PW-1:0]           h0_pos_ff, h0_pos_in, h1_pos_ff, h1_pos_in;

   // output register and skid stage
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rsp_val_ff, rsp_val_in;
   logic                    rsp_eos_ff, rsp_eos_in;
   logic                    skid_valid_ff, skid_valid_in;
   logic [SAMPLE_WIDTH-1:0] skid_val_ff, skid_val_in;
   logic                    skid_eos_ff, skid_eos_in;

   logic                    accept;
   logic                    neg;
   logic [PW:0]             age;
   logic                    pop_age, pop;
   logic [CW-1:0]           cnt_a, c1, c2;
   logic [SAMPLE_WIDTH-1:0] q_val, f0_val, f1_val;
   logic [PW-1:0]           q_pos, f0_pos, f1_pos;
   logic [IW:0]             head_inc, tail_inc;
   logic [IW-1:0]           head_adv, tail_adv;
   logic [IW+1:0]           rd_sum;
   logic [IW-1:0]           rd_addr;
   logic [PW:0]             pos_inc;
   logic                    produce;
   logic [SAMPLE_WIDTH-1:0] res_val;
   logic [31:0]             wl_ext;
   logic [CW-1:0]           wlen_eff;
   logic                    out_free;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign neg       = req_sample[SAMPLE_WIDTH-1];

   // third entry: registered read, or the write that hit the same slot
   assign q_val = fwd_ff ? fwd_val_ff : rd_val_ff;
   assign q_pos = fwd_ff ? fwd_pos_ff : rd_pos_ff;

   // window length clamp: zero means 1, above depth saturates
   assign wl_ext = {{(32-CSR_WIDTH){1'b0}}, csr_wr_data};
   always_comb begin
      if (wl_ext == 32'd0) begin
         wlen_eff = CW'(1);
      end else if (wl_ext > 32'(WINDOW_MAX)) begin
         wlen_eff = CW'(WINDOW_MAX);
      end else begin
         wlen_eff = wl_ext[CW-1:0];
      end
   end

   always_comb begin
      // age of the head entry, modulo 2*W
      if (pos_ff >= h0_pos_ff) begin
         age = {1'b0, pos_ff} - {1'b0, h0_pos_ff};
      end else begin
         age = {1'b0, pos_ff} + (PW+1)'(2 * WINDOW_MAX) - {1'b0, h0_pos_ff};
      end
      pop_age = (count_ff != '0) && (age >= (PW+1)'(wlen_ff));
      cnt_a   = count_ff - CW'(pop_age);
      // full queue with a push pending drops its oldest entry
      pop     = pop_age || (neg && (cnt_a == CW'(WINDOW_MAX)));
      c1      = count_ff - CW'(pop);
      c2      = c1 + CW'(neg);

      f0_val = pop ? h1_val_ff : h0_val_ff;
      f0_pos = pop ? h1_pos_ff : h0_pos_ff;
      f1_val = pop ? q_val : h1_val_ff;
      f1_pos = pop ? q_pos : h1_pos_ff;

      h0_val_in = f0_val;
      h0_pos_in = f0_pos;
      h1_val_in = f1_val;
      h1_pos_in = f1_pos;
      if (neg && (c1 == '0)) begin
         h0_val_in = req_sample;
         h0_pos_in = pos_ff;
      end
      if (neg && (c1 == CW'(1))) begin
         h1_val_in = req_sample;
         h1_pos_in = pos_ff;
      end

      head_inc = {1'b0, head_ff} + (IW+1)'(1);
      head_adv = (head_inc >= (IW+1)'(WINDOW_MAX)) ? '0 : head_inc[IW-1:0];
      tail_inc = {1'b0, tail_ff} + (IW+1)'(1);
      tail_adv = (tail_inc >= (IW+1)'(WINDOW_MAX)) ? '0 : tail_inc[IW-1:0];
      pos_inc  = {1'b0, pos_ff} + (PW+1)'(1);

      seen_in  = (seen_ff < wlen_ff) ? seen_ff + CW'(1) : wlen_ff;
      produce  = accept && (seen_in == wlen_ff);
      res_val  = (c2 != '0) ? h0_val_in : '0;

      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      if (accept) begin
         if (req_last_sample) begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
            pos_in   = '0;
            seen_in  = '0;
         end else begin
            head_in  = pop ? head_adv : head_ff;
            tail_in  = neg ? tail_adv : tail_ff;
            count_in = c2;
            pos_in   = (pos_inc == (PW+1)'(2 * WINDOW_MAX)) ? '0 : pos_inc[PW-1:0];
         end
      end else begin
         seen_in = seen_ff;
      end

      // prefetch slot head+2 for the next cycle
      rd_sum  = {2'b0, head_in} + (IW+2)'(2);
      rd_addr = (rd_sum >= (IW+2)'(WINDOW_MAX)) ?
                IW'(rd_sum - (IW+2)'(WINDOW_MAX)) : rd_sum[IW-1:0];
   end

   // output register with a skid stage behind it
   assign out_free = !rsp_valid_ff || rsp_ready;
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_eos_in    = rsp_eos_ff;
      skid_valid_in = skid_valid_ff;
      skid_val_in   = skid_val_ff;
      skid_eos_in   = skid_eos_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_val_in    = skid_val_ff;
            rsp_eos_in    = skid_eos_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = produce;
            rsp_val_in   = res_val;
            rsp_eos_in   = req_last_sample;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_val_in   = res_val;
         skid_eos_in   = req_last_sample;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_first_negative = rsp_val_ff;
   assign rsp_end_of_stream  = rsp_eos_ff;

   // entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (accept && neg) begin
         val_mem[tail_ff] <= req_sample;
         pos_mem[tail_ff] <= pos_ff;
      end
      rd_val_ff  <= val_mem[rd_addr];
      rd_pos_ff  <= pos_mem[rd_addr];
      fwd_val_ff <= req_sample;
      fwd_pos_ff <= pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         pos_ff        <= '0;
         seen_ff       <= '0;
         wlen_ff       <= CW'(WLEN_RESET);
         fwd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         pos_ff        <= pos_in;
         seen_ff       <= seen_in;
         if (csr_wr_en) begin
            wlen_ff <= wlen_eff;
         end
         fwd_ff        <= accept && neg && (tail_ff == rd_addr);
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         h0_val_ff <= h0_val_in;
         h0_pos_ff <= h0_pos_in;
         h1_val_ff <= h1_val_in;
         h1_pos_ff <= h1_pos_in;
      end
      rsp_val_ff  <= rsp_val_in;
      rsp_eos_ff  <= rsp_eos_in;
      skid_val_ff <= skid_val_in;
      skid_eos_ff <= skid_eos_in;
   end

   // tail must sit count slots past head
   logic [IW+CW:0] ring_sum;
   logic [IW+CW:0] ring_wrap;
   logic           ring_ok;
   assign ring_sum  = (IW+CW+1)'(head_ff) + (IW+CW+1)'(count_ff);
   assign ring_wrap = (ring_sum >= (IW+CW+1)'(WINDOW_MAX)) ?
                      ring_sum - (IW+CW+1)'(WINDOW_MAX) : ring_sum;
   assign ring_ok   = ring_wrap == (IW+CW+1)'(tail_ff);

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(WINDOW_MAX), "queue overfilled")
   `ASSERT_ALWAYS(a_ring, clock, reset, ring_ok, "head, tail and count disagree")
   `ASSERT_ALWAYS(a_skid_behind, clock, reset, !skid_valid_ff || rsp_valid_ff, "skid without output")
   `ASSERT_NEXT(a_last_clears, clock, reset, accept && req_last_sample, count_ff == '0 && seen_ff == '0, "stream end did not clear")
   `ASSERT_ALWAYS(a_wlen_range, clock, reset, wlen_ff != '0 && wlen_ff <= CW'(WINDOW_MAX), "window length out of range")

endmodule
